// ===== design/stable_priority_queue_defines.svh =====
// Assertion macros used by the priority queue back end.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define SPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// Types and constants of the stable priority queue.
package spq_pkg;

	localparam int PRI_W = 8;
	localparam int PAY_W = 32;
	localparam int OCC_W = 5;
	// at most this many entries leave per bulk pop request
	localparam int MAX_RESULTS = 16;
	localparam int BULK_CNT_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_BULK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_REMOVED  = 2'd0,
		ST_INSERTED = 2'd1,
		ST_FULL     = 2'd2,
		ST_NONE     = 2'd3
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [PRI_W-1:0] pri;
		logic [PAY_W-1:0] payload;
	} cmd_t;

	typedef struct packed {
		status_t          status;
		logic [PRI_W-1:0] pri;
		logic [PAY_W-1:0] payload;
		logic             last;
		logic [OCC_W-1:0] occupancy;
	} res_t;

endpackage

// ===== design/spq_front.sv =====
// Front end: decodes incoming items into commands and buffers them in a two-entry queue.
module spq_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     in_op,
	input  logic [7:0]     in_pri,
	input  logic [31:0]    in_payload,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output spq_pkg::cmd_t  cmd
);

	spq_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;
	spq_pkg::cmd_t dec;

	// classify the raw item
	always_comb begin
		dec.op      = spq_pkg::op_t'(in_op);
		dec.pri     = in_pri;
		dec.payload = in_payload;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/spq_back.sv =====
// Back end: sorted entry array, command execution and the output register.
`include "stable_priority_queue_defines.svh"

module spq_back #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  spq_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output spq_pkg::res_t res
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_BULK
	} state_t;

	state_t                       state_q;
	state_t                       state_n;
	logic [CW-1:0]                count_q;
	logic [spq_pkg::PRI_W-1:0]    pri_q [DEPTH];
	logic [spq_pkg::PAY_W-1:0]    pay_q [DEPTH];
	logic [spq_pkg::PRI_W-1:0]    thr_q;
	logic [spq_pkg::PRI_W-1:0]    thr_n;
	logic [spq_pkg::BULK_CNT_W-1:0] n_q;
	logic [spq_pkg::BULK_CNT_W-1:0] n_n;
	logic                         res_valid_q;
	spq_pkg::res_t                res_q;
	spq_pkg::res_t                res_n;
	logic                         res_load;

	logic                         out_free;
	logic                         full;
	logic [spq_pkg::PRI_W-1:0]    key;
	logic [DEPTH-1:0]             keep;
	logic [DEPTH-1:0]             keep_prev;
	logic [DEPTH-1:0]             eq;
	logic [DEPTH-1:0]             from_match;
	logic                         any_eq;
	logic [spq_pkg::PAY_W-1:0]    match_pay;
	logic                         head_ok;
	logic                         next_ok;
	logic                         do_ins;
	logic                         do_rem;
	logic [DEPTH-1:0]             rem_mask;
	logic [CW-1:0]                count_n;
	logic [spq_pkg::PRI_W-1:0]    prev_pri [DEPTH];
	logic [spq_pkg::PAY_W-1:0]    prev_pay [DEPTH];
	logic [spq_pkg::PRI_W-1:0]    next_pri [DEPTH];
	logic [spq_pkg::PAY_W-1:0]    next_pay [DEPTH];

	assign out_free  = !res_valid_q || res_ready;
	assign full      = (count_q == CW'(DEPTH));
	assign key       = (state_q == S_BULK) ? thr_q : cmd.pri;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// parallel compare against every held entry
	always_comb begin
		logic seen;
		seen      = 1'b0;
		match_pay = '0;
		for (int i = 0; i < DEPTH; i++) begin
			keep[i]       = (CW'(i) < count_q) && (pri_q[i] <= cmd.pri);
			eq[i]         = (CW'(i) < count_q) && (pri_q[i] == cmd.pri);
			if (eq[i] && !seen) begin
				match_pay = pay_q[i];
			end
			from_match[i] = eq[i] || seen;
			seen          = seen || eq[i];
		end
		any_eq = seen;
	end

	// neighbor taps for shifting up and down
	always_comb begin
		prev_pri[0]  = cmd.pri;
		prev_pay[0]  = cmd.payload;
		keep_prev[0] = 1'b1;
		for (int i = 1; i < DEPTH; i++) begin
			prev_pri[i]  = pri_q[i-1];
			prev_pay[i]  = pay_q[i-1];
			keep_prev[i] = keep[i-1];
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			next_pri[i] = pri_q[i+1];
			next_pay[i] = pay_q[i+1];
		end
		next_pri[DEPTH-1] = pri_q[DEPTH-1];
		next_pay[DEPTH-1] = pay_q[DEPTH-1];
	end

	assign head_ok = (count_q != '0) && (pri_q[0] <= key);
	assign next_ok = (count_q > CW'(1)) && (pri_q[1] <= key);

	always_comb begin
		cmd_ready = 1'b0;
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		rem_mask  = '1;
		res_load  = 1'b0;
		state_n   = state_q;
		n_n       = n_q;
		thr_n     = thr_q;
		count_n   = count_q;
		res_n     = '{status: spq_pkg::ST_NONE, pri: '0, payload: '0, last: 1'b1,
			occupancy: '0};
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_ready = 1'b1;
					res_load  = 1'b1;
					unique case (cmd.op)
						spq_pkg::OP_INSERT: begin
							if (full) begin
								res_n.status = spq_pkg::ST_FULL;
							end else begin
								do_ins       = 1'b1;
								count_n      = count_q + CW'(1);
								res_n.status = spq_pkg::ST_INSERTED;
							end
						end
						spq_pkg::OP_POP: begin
							if (count_q != '0) begin
								do_rem        = 1'b1;
								count_n       = count_q - CW'(1);
								res_n.status  = spq_pkg::ST_REMOVED;
								res_n.pri     = pri_q[0];
								res_n.payload = pay_q[0];
							end
						end
						spq_pkg::OP_REMOVE: begin
							if (any_eq) begin
								do_rem        = 1'b1;
								rem_mask      = from_match;
								count_n       = count_q - CW'(1);
								res_n.status  = spq_pkg::ST_REMOVED;
								res_n.pri     = cmd.pri;
								res_n.payload = match_pay;
							end
						end
						spq_pkg::OP_BULK: begin
							if (head_ok) begin
								do_rem        = 1'b1;
								count_n       = count_q - CW'(1);
								res_n.status  = spq_pkg::ST_REMOVED;
								res_n.pri     = pri_q[0];
								res_n.payload = pay_q[0];
								res_n.last    = !(next_ok && (spq_pkg::MAX_RESULTS > 1));
								if (!res_n.last) begin
									state_n = S_BULK;
									n_n     = spq_pkg::BULK_CNT_W'(1);
									thr_n   = cmd.pri;
								end
							end
						end
					endcase
				end
			end
			S_BULK: begin
				// head is known to qualify: the previous step checked it
				if (out_free) begin
					res_load      = 1'b1;
					do_rem        = 1'b1;
					count_n       = count_q - CW'(1);
					res_n.status  = spq_pkg::ST_REMOVED;
					res_n.pri     = pri_q[0];
					res_n.payload = pay_q[0];
					res_n.last    = !(next_ok &&
						((n_q + spq_pkg::BULK_CNT_W'(1)) <
						spq_pkg::BULK_CNT_W'(spq_pkg::MAX_RESULTS)));
					n_n           = n_q + spq_pkg::BULK_CNT_W'(1);
					if (res_n.last) begin
						state_n = S_IDLE;
					end
				end
			end
		endcase
		res_n.occupancy = spq_pkg::OCC_W'(count_n);
	end

	// entry array: insert shifts the tail up, removal shifts it down
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (do_ins) begin
				if (!keep[i]) begin
					pri_q[i] <= keep_prev[i] ? cmd.pri : prev_pri[i];
					pay_q[i] <= keep_prev[i] ? cmd.payload : prev_pay[i];
				end
			end else if (do_rem && rem_mask[i]) begin
				pri_q[i] <= next_pri[i];
				pay_q[i] <= next_pay[i];
			end
		end
		if (res_load) begin
			res_q <= res_n;
		end
		thr_q <= thr_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			n_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			n_q     <= n_n;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	`SPQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
	`SPQ_ASSERT_IMPL(a_bulk_cnt, state_q == S_BULK,
		(n_q != '0) && (n_q < spq_pkg::BULK_CNT_W'(spq_pkg::MAX_RESULTS)),
		"bulk pop counter out of range")
	`SPQ_ASSERT_IMPL(a_not_last, res_valid_q && !res_q.last, state_q == S_BULK,
		"non-final result outside a bulk pop")
	`SPQ_ASSERT_NEXT(a_ins_count, cmd_ready && (cmd.op == spq_pkg::OP_INSERT) && !full,
		count_q == $past(count_q) + CW'(1), "insert did not grow the queue")

endmodule

// ===== design/stable_priority_queue.sv =====
// Top level of the stable priority queue.
// Bounded queue of (priority, payload) entries held in ascending priority
// order, first in first out among equal priorities.
// Input channel s_*: s_tuser = operation (insert, pop head, remove by priority,
// bulk pop at or below threshold), s_tdata = priority_req and payload.
// Output channel m_*: m_tuser = status, m_tdata = removed priority, payload and
// occupancy, m_tlast marks the final result of one request.
// An accepted item is registered in the command queue, then executes straight
// into the output register once that register is free. Insert, pop and remove
// each give one result; a bulk pop emits one result per cycle while the
// receiver keeps up, up to 16, and holds off new commands until its final
// result. The single sorted shift array, which does one insert or one removal
// per cycle, sets these rates.
// Reset clears the entry count and both queues; stored entries keep garbage
// that is never read. When the receiver stalls, the output register holds its
// result, the execution stage waits, and the two-entry command queue keeps
// taking items until it fills, then drops s_tready.
module stable_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [7:0] priority_req, [39:8] payload
	input  logic [1:0]  s_tuser,  // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [7:0] out_priority, [39:8] out_payload,
	                              // [44:40] occupancy, [47:45] zero
	output logic [1:0]  m_tuser,  // [1:0] status
	output logic        m_tlast   // final result of the request
);

	logic          cmd_valid;
	logic          cmd_ready;
	spq_pkg::cmd_t cmd;
	spq_pkg::res_t res;

	spq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_pri     (s_tdata[7:0]),
		.in_payload (s_tdata[39:8]),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	spq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack the result item
	assign m_tdata = {3'b000, res.occupancy, res.payload, res.pri};
	assign m_tuser = res.status;
	assign m_tlast = res.last;

endmodule
